// File: rtl/core/agr_pkg.sv
// Shared types, constants and the bandwidth limit function for gain ranging
package agr_pkg;

    // Number of gain codes and the clipping guard band in ADC counts
    localparam int GAIN_STEPS    = 11;
    localparam int SAFETY_MARGIN = 100;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 4;
    localparam int FREQ_W   = 23;
    localparam int MARGIN_W = 12;
    localparam int CFG_IDX_W = 1;

    // Gain-bandwidth product times eight, in Hz
    localparam logic [25:0] GBW_X8 = 26'd48000000;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(GAIN_STEPS - 1);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3);

    // Extremes after a clear
    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 12'sd2047;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = -12'sd2048;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_FREQUENCY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INCREASE_MARGIN  = 1'b1;

    // Item kinds
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_DECREASED = 2'd0,
        VERDICT_INCREASED = 2'd1,
        VERDICT_HOLD      = 2'd2,
        VERDICT_OVERLOAD  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic                       action;
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } item_t;

    typedef struct packed {
        logic              result_channel;
        verdict_t          verdict;
        logic [GAIN_W-1:0] gain_index;
    } result_t;

    // Largest k below GAIN_STEPS with freq * 2^k within the GBW budget, else 0
    function automatic logic [GAIN_W-1:0] compute_limit(input logic [FREQ_W-1:0] freq);
        logic [GAIN_W-1:0] lim;
        lim = '0;
        for (int k = 1; k < GAIN_STEPS; k++) begin
            if ({3'b000, freq} <= (GBW_X8 >> k)) begin
                lim = GAIN_W'(k);
            end
        end
        return lim;
    endfunction

endpackage

// File: rtl/core/auto_gain_ranging.sv
// Top level of the amplifier gain auto-ranging block
// Slave stream s_*: one item per transfer. tuser[0] is the kind (0 start
// ranging, 1 ADC sample), tuser[1] the channel, tdata[11:0] the signed sample
// and tlast marks the final sample of a waveform.
// Master stream m_*: one result per waveform end, carrying the verdict and the
// new gain code in tdata and the channel in tuser. Start items and other
// samples give no result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 signal
// frequency, 1 increase margin); write only while no item is in flight.
// Path: a waveform end passes the input register and, once there is room,
// the combinational decision into the result register, which drives m_tvalid.
// Throughput: one item per cycle when not stalled (see Stall); all work sits
// in a single combinational step between the input and result registers.
// Reset: both channels return to gain code 3, the bandwidth limit to the top
// code, the extremes are cleared and both streams go empty.
// Stall: a held result still lets one more item in, and items without a
// result keep flowing; s_tready drops only when a waveform end is waiting
// for the result register.
module auto_gain_ranging
    import agr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [1:0]           s_tuser,   // [0] action, [1] channel
    input  logic                 s_tlast,   // last_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [1:0] verdict, [5:2] gain_index, [7:6] zero
    output logic                 m_tuser,   // result_channel
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FREQ_W-1:0]    cfg_data
);

    logic [FREQ_W-1:0]   freq_reg;
    logic [FREQ_W-1:0]   freq_next;
    logic [MARGIN_W-1:0] margin_reg;
    logic [MARGIN_W-1:0] margin_next;

    logic    item_valid;
    item_t   item;
    logic    take;
    logic    res_load;
    result_t res;
    logic    out_free;

    // Decode configuration writes
    always_comb
    begin
        freq_next   = freq_reg;
        margin_next = margin_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIGNAL_FREQUENCY: freq_next   = cfg_data;
                REG_INCREASE_MARGIN:  margin_next = cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= FREQ_W'(1000);
            margin_reg <= MARGIN_W'(1023);
        end
        else
        begin
            freq_reg   <= freq_next;
            margin_reg <= margin_next;
        end
    end

    agr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    agr_range_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item             (item),
        .out_free         (out_free),
        .signal_frequency (freq_reg),
        .increase_margin  (margin_reg),
        .take             (take),
        .res_load         (res_load),
        .res              (res)
    );

    agr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/core/agr_in_reg.sv
// Input register: captures one item from the slave stream
module agr_in_reg
    import agr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [1:0]  s_tuser,   // [0] action, [1] channel
    input  logic        s_tlast,   // last_sample
    input  logic        take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until a new item is taken
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.action      <= s_tuser[0];
            item_reg.channel     <= s_tuser[1];
            item_reg.sample      <= $signed(s_tdata[SAMPLE_W-1:0]);
            item_reg.last_sample <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/agr_range_core.sv
// Ranging state and decision: gain store, bandwidth limit and running extremes
module agr_range_core
    import agr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  item_t               item,
    input  logic                out_free,
    input  logic [FREQ_W-1:0]   signal_frequency,
    input  logic [MARGIN_W-1:0] increase_margin,
    output logic                take,
    output logic                res_load,
    output result_t             res
);

    localparam logic signed [13:0] HEAD_BASE = 14'(2047 - SAFETY_MARGIN);
    localparam logic signed [13:0] FOOT_BASE = 14'(-2048 + SAFETY_MARGIN);

    logic [GAIN_W-1:0]          gain_reg [2];
    logic [GAIN_W-1:0]          gain_next [2];
    logic [GAIN_W-1:0]          limit_reg;
    logic [GAIN_W-1:0]          limit_next;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] min_next;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic signed [SAMPLE_W-1:0] max_next;

    logic                       ends_wave;
    logic signed [SAMPLE_W-1:0] upd_min;
    logic signed [SAMPLE_W-1:0] upd_max;
    logic signed [13:0]         head;
    logic signed [13:0]         foot;
    logic signed [13:0]         margin_s;
    logic [GAIN_W-1:0]          cur_gain;
    logic [GAIN_W-1:0]          new_gain;
    logic [GAIN_W-1:0]          new_limit;
    verdict_t                   verdict;

    // Only a waveform end needs room in the result register
    assign ends_wave = (item.action == ACT_SAMPLE) && item.last_sample;
    assign take      = item_valid && (!ends_wave || out_free);
    assign res_load  = take && ends_wave;

    // Fold the sample into the extremes
    assign upd_min = (item.sample < min_reg) ? item.sample : min_reg;
    assign upd_max = (item.sample > max_reg) ? item.sample : max_reg;

    // Headroom, footroom and the increase threshold as signed values
    assign head     = HEAD_BASE - {{2{upd_max[SAMPLE_W-1]}}, upd_max};
    assign foot     = {{2{upd_min[SAMPLE_W-1]}}, upd_min} - FOOT_BASE;
    assign margin_s = $signed({2'b00, increase_margin});

    assign cur_gain  = gain_reg[item.channel];
    assign new_limit = compute_limit(signal_frequency);

    // Decide the gain step
    always_comb
    begin
        new_gain = cur_gain;
        verdict  = VERDICT_HOLD;
        if (head < 0 || foot < 0)
        begin
            if (cur_gain != '0)
            begin
                new_gain = cur_gain - GAIN_W'(1);
                verdict  = VERDICT_DECREASED;
            end
            else
            begin
                verdict = VERDICT_OVERLOAD;
            end
        end
        else if (head > margin_s && foot > margin_s)
        begin
            if (cur_gain < limit_reg)
            begin
                new_gain = cur_gain + GAIN_W'(1);
                verdict  = VERDICT_INCREASED;
            end
        end
    end

    // Next state for start and sample items
    always_comb
    begin
        gain_next  = gain_reg;
        limit_next = limit_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (take)
        begin
            if (item.action == ACT_START)
            begin
                limit_next = new_limit;
                if (cur_gain > new_limit)
                begin
                    gain_next[item.channel] = new_limit;
                end
                min_next = MIN_RESET;
                max_next = MAX_RESET;
            end
            else if (item.last_sample)
            begin
                gain_next[item.channel] = new_gain;
                min_next = MIN_RESET;
                max_next = MAX_RESET;
            end
            else
            begin
                min_next = upd_min;
                max_next = upd_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0] <= GAIN_RESET;
            gain_reg[1] <= GAIN_RESET;
            limit_reg   <= GAIN_MAX;
            min_reg     <= MIN_RESET;
            max_reg     <= MAX_RESET;
        end
        else
        begin
            gain_reg  <= gain_next;
            limit_reg <= limit_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    assign res.result_channel = item.channel;
    assign res.verdict        = verdict;
    assign res.gain_index     = new_gain;

`ifndef SYNTHESIS
    // Stored gain codes never leave the table
    assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg[0] <= GAIN_MAX && gain_reg[1] <= GAIN_MAX)
        else $error("gain code beyond table");

    // A waveform end clears the extremes
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (min_reg == MIN_RESET && max_reg == MAX_RESET))
        else $error("extremes not cleared after waveform end");

    // An increase on channel 0 stores the reported code for that channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.verdict == VERDICT_INCREASED && !res.result_channel)
        |=> gain_reg[0] == $past(res.gain_index))
        else $error("increased gain not stored");

    // Overload is only reported at the lowest gain
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.verdict == VERDICT_OVERLOAD) |-> res.gain_index == '0)
        else $error("overload reported above lowest gain");
`endif

endmodule

// File: rtl/core/agr_out_reg.sv
// Result register: holds one result item for the master stream
module agr_out_reg
    import agr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    res,
    output logic       out_free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] verdict, [5:2] gain_index, [7:6] zero
    output logic       m_tuser    // result_channel
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Room when empty or when the held item leaves this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.gain_index, res_reg.verdict};
    assign m_tuser  = res_reg.result_channel;

endmodule
